>>> sv/prib_pkg.sv
// ============================================================================
// prib_pkg
// Shared types and constants for the predict/replay input buffer.
// ============================================================================
package prib_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int POS_WIDTH_DEF  = 32;
    localparam int FLD_W          = 32;
    localparam int CNT_W          = 7;

    typedef enum logic [1:0] {
        REQ_BIND      = 2'd0,
        REQ_PREDICT   = 2'd1,
        REQ_RECONCILE = 2'd2,
        REQ_UNUSED    = 2'd3
    } t_req;

endpackage

>>> sv/prib_sat_add.sv
// ============================================================================
// prib_sat_add
// Saturating signed add of a 32-bit move onto a POS_WIDTH-bit position.
// ============================================================================
module prib_sat_add #(
    parameter int POS_WIDTH = prib_pkg::POS_WIDTH_DEF
) (
    input  logic signed [POS_WIDTH-1:0]        i_pos,
    input  logic signed [prib_pkg::FLD_W-1:0]  i_move,
    output logic signed [POS_WIDTH-1:0]        o_sum
);
    import prib_pkg::*;

    localparam int SW = ((POS_WIDTH > FLD_W) ? POS_WIDTH : FLD_W) + 2;

    logic signed [SW-1:0] w_sum;
    logic signed [SW-1:0] w_max;
    logic signed [SW-1:0] w_min;

    always_comb begin
        w_sum = SW'(i_pos) + SW'(i_move);
        w_max = SW'({1'b0, {(POS_WIDTH-1){1'b1}}});
        w_min = -w_max - SW'(1);
        if (w_sum > w_max) begin
            o_sum = w_max[POS_WIDTH-1:0];
        end else if (w_sum < w_min) begin
            o_sum = w_min[POS_WIDTH-1:0];
        end else begin
            o_sum = w_sum[POS_WIDTH-1:0];
        end
    end

endmodule

>>> sv/predict_replay_input_buffer.sv
// ============================================================================
// predict_replay_input_buffer
// Client-side prediction with a command ring and server reconciliation.
// ============================================================================
// Usage:
//   Raise i_start with a request on the i_* ports while o_busy is low; the
//   item is taken at that edge. One result per item appears on the o_*
//   ports for exactly one cycle, marked by o_done; the receiver cannot stall.
//   Bind loads a position, resets the sequence counter to 1, empties ring.
//   Predict stamps the next sequence, adds the move (saturating) and stores
//   the command unless the ring holds RING_DEPTH entries.
//   Reconcile drops acked commands from the oldest, loads the authority
//   position and replays the remaining moves.
// Sequencing:
//   Bind, predict and unused codes: execute state, then result state.
//   Reconcile: the ring memory is read one entry per cycle (registered
//   read), first through the drop scan, then through the replay; only the
//   first kept entry is read twice.
//   One item at a time; o_busy is high from accept through the result cycle.
// Reset: synchronous active-low; position 0, ring empty, sequence 1. The
//   ring memory itself is not cleared; only written entries are ever used.
// ============================================================================
module predict_replay_input_buffer #(
    parameter int RING_DEPTH = prib_pkg::RING_DEPTH_DEF,
    parameter int POS_WIDTH  = prib_pkg::POS_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_req_type,
    input  logic [prib_pkg::FLD_W-1:0]        i_tick,
    input  logic signed [prib_pkg::FLD_W-1:0] i_move_x,
    input  logic signed [prib_pkg::FLD_W-1:0] i_move_y,
    input  logic signed [prib_pkg::FLD_W-1:0] i_move_z,
    input  logic signed [prib_pkg::FLD_W-1:0] i_pos_x,
    input  logic signed [prib_pkg::FLD_W-1:0] i_pos_y,
    input  logic signed [prib_pkg::FLD_W-1:0] i_pos_z,
    input  logic [prib_pkg::FLD_W-1:0]        i_acked_seq,
    output logic                              o_done,
    output logic signed [prib_pkg::FLD_W-1:0] o_out_x,
    output logic signed [prib_pkg::FLD_W-1:0] o_out_y,
    output logic signed [prib_pkg::FLD_W-1:0] o_out_z,
    output logic [prib_pkg::FLD_W-1:0]        o_cmd_seq,
    output logic [prib_pkg::FLD_W-1:0]        o_cmd_tick,
    output logic                              o_buffered,
    output logic [prib_pkg::CNT_W-1:0]        o_dropped_count,
    output logic [prib_pkg::CNT_W-1:0]        o_pending_count,
    output logic [prib_pkg::FLD_W-1:0]        o_last_applied_seq
);
    import prib_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int EW = 4 * FLD_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EXEC  = 6'b000010,
        ST_DSCAN = 6'b000100,
        ST_RLOAD = 6'b001000,
        ST_RPLAY = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    // Ring memory: {seq, mx, my, mz}
    logic [EW-1:0] r_mem [RING_DEPTH];
    logic [EW-1:0] r_rdata;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;

    t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [FLD_W-1:0] r_next_seq, n_next_seq;
    logic [FLD_W-1:0] r_last, n_last;
    logic signed [POS_WIDTH-1:0] r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic [CW-1:0] r_k, n_k;          // scan / replay index
    logic [CW-1:0] r_drop, n_drop;
    logic          r_rd_ok, n_rd_ok;  // valid flag for r_rdata; never set, stays low
    logic [FLD_W-1:0] r_seq_o, n_seq_o, r_tick_o, n_tick_o;
    logic          r_buf_o, n_buf_o;

    // latched request
    t_req             r_req;
    logic [FLD_W-1:0] r_tick, r_ack;
    logic signed [FLD_W-1:0] r_mx, r_my, r_mz, r_ax, r_ay, r_az;

    logic signed [FLD_W-1:0] w_ax, w_ay, w_az;
    logic signed [POS_WIDTH-1:0] w_sx, w_sy, w_sz;
    logic signed [POS_WIDTH-1:0] w_lx, w_ly, w_lz;

    always_comb begin
        if (r_state == ST_RPLAY) begin
            w_ax = r_rdata[3*FLD_W-1:2*FLD_W];
            w_ay = r_rdata[2*FLD_W-1:FLD_W];
            w_az = r_rdata[FLD_W-1:0];
        end else begin
            w_ax = r_mx;
            w_ay = r_my;
            w_az = r_mz;
        end
    end

    prib_sat_add #(.POS_WIDTH(POS_WIDTH)) u_add_x (.i_pos(r_px), .i_move(w_ax), .o_sum(w_sx));
    prib_sat_add #(.POS_WIDTH(POS_WIDTH)) u_add_y (.i_pos(r_py), .i_move(w_ay), .o_sum(w_sy));
    prib_sat_add #(.POS_WIDTH(POS_WIDTH)) u_add_z (.i_pos(r_pz), .i_move(w_az), .o_sum(w_sz));

    // load of a 32-bit position into POS_WIDTH (clamped when narrower)
    function automatic logic signed [POS_WIDTH-1:0] load_pos(input logic signed [FLD_W-1:0] v);
        logic signed [FLD_W+POS_WIDTH-1:0] w;
        logic signed [FLD_W+POS_WIDTH-1:0] mx;
        logic signed [FLD_W+POS_WIDTH-1:0] mn;
        w  = (FLD_W+POS_WIDTH)'(v);
        mx = (FLD_W+POS_WIDTH)'({1'b0, {(POS_WIDTH-1){1'b1}}});
        mn = -mx - (FLD_W+POS_WIDTH)'(1);
        if (w > mx) return mx[POS_WIDTH-1:0];
        if (w < mn) return mn[POS_WIDTH-1:0];
        return w[POS_WIDTH-1:0];
    endfunction

    always_comb begin
        w_lx = load_pos(r_ax);
        w_ly = load_pos(r_ay);
        w_lz = load_pos(r_az);
    end

    // memory read address: entry r_k of the ring
    always_comb begin
        logic [CW:0] s;
        s = (CW+1)'(r_head) + (CW+1)'(r_k);
        if (s >= (CW+1)'(RING_DEPTH)) s = s - (CW+1)'(RING_DEPTH);
        w_raddr = s[AW-1:0];
    end

    always_comb begin
        logic [CW:0] s;
        s = (CW+1)'(r_head) + (CW+1)'(r_count);
        if (s >= (CW+1)'(RING_DEPTH)) s = s - (CW+1)'(RING_DEPTH);
        w_waddr = s[AW-1:0];
        w_we    = (r_state == ST_EXEC) && (r_req == REQ_PREDICT)
                  && (r_count < CW'(RING_DEPTH));
        w_wdata = {r_next_seq, r_mx, r_my, r_mz};
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_req  <= t_req'(i_req_type);
            r_tick <= i_tick;
            r_ack  <= i_acked_seq;
            r_mx   <= i_move_x;
            r_my   <= i_move_y;
            r_mz   <= i_move_z;
            r_ax   <= i_pos_x;
            r_ay   <= i_pos_y;
            r_az   <= i_pos_z;
        end
    end

    always_comb begin
        logic [CW:0] s;
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_next_seq = r_next_seq;
        n_last     = r_last;
        n_px       = r_px;
        n_py       = r_py;
        n_pz       = r_pz;
        n_k        = r_k;
        n_drop     = r_drop;
        n_rd_ok    = 1'b0;
        n_seq_o    = r_seq_o;
        n_tick_o   = r_tick_o;
        n_buf_o    = r_buf_o;
        s          = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state  = ST_EXEC;
                    n_seq_o  = '0;
                    n_tick_o = '0;
                    n_buf_o  = 1'b0;
                    n_drop   = '0;
                    n_k      = '0;
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                case (r_req)
                    REQ_BIND: begin
                        n_px = w_lx; n_py = w_ly; n_pz = w_lz;
                        n_next_seq = FLD_W'(1);
                        n_head = '0;
                        n_count = '0;
                    end
                    REQ_PREDICT: begin
                        n_px = w_sx; n_py = w_sy; n_pz = w_sz;
                        n_seq_o = r_next_seq;
                        n_tick_o = r_tick;
                        n_next_seq = r_next_seq + FLD_W'(1);
                        if (w_we) begin
                            n_count = r_count + CW'(1);
                            n_buf_o = 1'b1;
                            n_last = r_next_seq;
                        end else if (r_count != '0) begin
                            // ring full: newest entry is unchanged
                            n_last = r_last;
                        end
                    end
                    REQ_RECONCILE: begin
                        n_px = w_lx; n_py = w_ly; n_pz = w_lz;
                        if (r_ack != '0 && r_count != '0) begin
                            n_state = ST_DSCAN;
                            n_k = CW'(1);     // entry 0 read this cycle
                        end else begin
                            n_state = ST_RLOAD;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DSCAN: begin
                // r_rdata = entry r_k-1
                if (r_rdata[EW-1:3*FLD_W] <= r_ack) begin
                    n_drop = r_drop + CW'(1);
                    if (r_drop + CW'(1) < r_count) begin
                        n_k = r_k + CW'(1);
                    end else begin
                        n_state = ST_RLOAD;
                    end
                end else begin
                    n_state = ST_RLOAD;
                end
                if (n_state == ST_RLOAD) begin
                    s = (CW+1)'(r_head) + (CW+1)'(n_drop);
                    if (s >= (CW+1)'(RING_DEPTH)) s = s - (CW+1)'(RING_DEPTH);
                    n_head  = s[AW-1:0];
                    n_count = r_count - n_drop;
                    n_k     = '0;
                end
            end
            ST_RLOAD: begin
                // address entry 0 issued this cycle
                if (r_count == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_RPLAY;
                    n_k = CW'(1);
                    if (r_count == CW'(1)) begin
                        n_last = '0;
                    end
                end
            end
            ST_RPLAY: begin
                n_px = w_sx; n_py = w_sy; n_pz = w_sz;
                if (r_k == r_count) begin
                    n_last  = r_rdata[EW-1:3*FLD_W];
                    n_state = ST_DONE;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_RLOAD && r_count == CW'(1)) n_last = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_count    <= '0;
            r_next_seq <= FLD_W'(1);
            r_last     <= '0;
            r_px       <= '0;
            r_py       <= '0;
            r_pz       <= '0;
            r_k        <= '0;
            r_drop     <= '0;
            r_rd_ok    <= 1'b0;
            r_seq_o    <= '0;
            r_tick_o   <= '0;
            r_buf_o    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_count    <= n_count;
            r_next_seq <= n_next_seq;
            r_last     <= n_last;
            r_px       <= n_px;
            r_py       <= n_py;
            r_pz       <= n_pz;
            r_k        <= n_k;
            r_drop     <= n_drop;
            r_rd_ok    <= n_rd_ok;
            r_seq_o    <= n_seq_o;
            r_tick_o   <= n_tick_o;
            r_buf_o    <= n_buf_o;
        end
    end

    // low 32 bits of the position, sign-extended when POS_WIDTH is narrower
    assign o_busy             = (r_state != ST_IDLE) || r_rd_ok;
    assign o_done             = (r_state == ST_DONE);
    assign o_out_x            = FLD_W'(r_px);
    assign o_out_y            = FLD_W'(r_py);
    assign o_out_z            = FLD_W'(r_pz);
    assign o_cmd_seq          = r_seq_o;
    assign o_cmd_tick         = r_tick_o;
    assign o_buffered         = r_buf_o;
    assign o_dropped_count    = CNT_W'(r_drop);
    assign o_pending_count    = CNT_W'(r_count);
    assign o_last_applied_seq = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RING_DEPTH)) else $error("ring count overflow");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result held more than one cycle");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("result while idle");
    a_drop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_drop <= CW'(RING_DEPTH))) else $error("drop count overflow");

endmodule

>>> tb/sv/predict_replay_input_buffer_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// predict_replay_input_buffer_tb
// Self-checking bench for the predict/replay input buffer: a local model of
// position, sequence counter and command ring predicts every result, which
// is compared field by field with the result strobed out by the block.
// ============================================================================
module predict_replay_input_buffer_tb;

    import prib_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;
    localparam logic signed [31:0] PMAX = 32'sh7fffffff;
    localparam logic signed [31:0] PMIN = 32'sh80000000;

    typedef struct packed {
        logic [31:0] ox, oy, oz, seq, tck;
        logic        buff;
        logic [6:0]  dropped, pending;
        logic [31:0] last;
    } t_result;

    typedef struct packed {
        logic [31:0]        seq;
        logic signed [31:0] mx, my, mz;
    } t_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic [1:0] i_req_type = '0;
    logic [31:0] i_tick = '0, i_acked_seq = '0;
    logic signed [31:0] i_move_x = '0, i_move_y = '0, i_move_z = '0;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic o_busy, o_done, o_buffered;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic [31:0] o_cmd_seq, o_cmd_tick, o_last_applied_seq;
    logic [6:0] o_dropped_count, o_pending_count;

    always #5 i_clk = ~i_clk;

    predict_replay_input_buffer dut (.*);

    // model state
    t_cmd               ring [DEPTH];
    int unsigned        head, count;
    logic [31:0]        next_seq, newest_seq;
    logic signed [31:0] px, py, pz;

    t_result expected_q[$];
    int      errors = 0;
    int      n_items = 0, n_predict = 0, n_reconcile = 0, n_full = 0;

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s > 33'sd2147483647) return PMAX;
        if (s < -33'sd2147483648) return PMIN;
        return s[31:0];
    endfunction

    // advance the model by one item and queue the result it must produce
    task automatic predict_result(t_req req, logic [31:0] tk,
                                  logic signed [31:0] mx, my, mz,
                                  logic signed [31:0] ax, ay, az,
                                  logic [31:0] ack);
        t_result r;
        int unsigned k;
        r = '0;
        case (req)
            REQ_BIND: begin
                px = ax; py = ay; pz = az;
                next_seq = 32'd1; head = 0; count = 0;
            end
            REQ_PREDICT: begin
                px = sat_add(px, mx); py = sat_add(py, my); pz = sat_add(pz, mz);
                r.seq = next_seq; r.tck = tk;
                if (count < DEPTH) begin
                    ring[(head + count) % DEPTH] = '{next_seq, mx, my, mz};
                    count++;
                    r.buff = 1'b1;
                end else n_full++;
                next_seq = next_seq + 32'd1;
                if (count > 0) newest_seq = ring[(head + count - 1) % DEPTH].seq;
            end
            REQ_RECONCILE: begin
                if (ack != 0) begin
                    while (r.dropped < count && ring[(head + r.dropped) % DEPTH].seq <= ack)
                        r.dropped++;
                    head = (head + r.dropped) % DEPTH;
                    count -= r.dropped;
                end
                px = ax; py = ay; pz = az;
                for (k = 0; k < count; k++) begin
                    px = sat_add(px, ring[(head + k) % DEPTH].mx);
                    py = sat_add(py, ring[(head + k) % DEPTH].my);
                    pz = sat_add(pz, ring[(head + k) % DEPTH].mz);
                end
                if (count > 0) newest_seq = ring[(head + count - 1) % DEPTH].seq;
            end
            default: ;  // unused code: nothing changes
        endcase
        r.ox = px; r.oy = py; r.oz = pz;
        r.pending = 7'(count);
        r.last = newest_seq;
        expected_q.push_back(r);
    endtask

    // send one item; driven at the rising edge, accepted when busy is low
    task automatic send_item(t_req req, logic [31:0] tk,
                             logic signed [31:0] mx, my, mz,
                             logic signed [31:0] ax, ay, az,
                             logic [31:0] ack);
        i_start     <= 1'b1;
        i_req_type  <= req;
        i_tick      <= tk;
        i_move_x    <= mx; i_move_y <= my; i_move_z <= mz;
        i_pos_x     <= ax; i_pos_y  <= ay; i_pos_z  <= az;
        i_acked_seq <= ack;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_result(req, tk, mx, my, mz, ax, ay, az, ack);
        n_items++;
        if (req == REQ_PREDICT) n_predict++;
        if (req == REQ_RECONCILE) n_reconcile++;
        i_start <= 1'b0;
        // block stays busy after accept, so this edge costs no throughput
        @(posedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return PMAX;
            1: return PMIN;
            2: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
            default: return $urandom();
        endcase
    endfunction

    // result checker: every strobe is matched against the oldest expectation
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_out_x !== e.ox) begin
                    $error("out_x exp %h got %h", e.ox, o_out_x); errors++; end
                if (o_out_y !== e.oy) begin
                    $error("out_y exp %h got %h", e.oy, o_out_y); errors++; end
                if (o_out_z !== e.oz) begin
                    $error("out_z exp %h got %h", e.oz, o_out_z); errors++; end
                if (o_cmd_seq !== e.seq) begin
                    $error("cmd_seq exp %h got %h", e.seq, o_cmd_seq); errors++; end
                if (o_cmd_tick !== e.tck) begin
                    $error("cmd_tick exp %h got %h", e.tck, o_cmd_tick); errors++; end
                if (o_buffered !== e.buff) begin
                    $error("buffered exp %b got %b", e.buff, o_buffered); errors++; end
                if (o_dropped_count !== e.dropped) begin
                    $error("dropped_count exp %0d got %0d", e.dropped, o_dropped_count);
                    errors++;
                end
                if (o_pending_count !== e.pending) begin
                    $error("pending_count exp %0d got %0d", e.pending, o_pending_count);
                    errors++;
                end
                if (o_last_applied_seq !== e.last) begin
                    $error("last_applied_seq exp %h got %h", e.last, o_last_applied_seq);
                    errors++;
                end
            end
        end
    end

    // extremes, saturation both ways, unused code, ack of zero
    task automatic test_directed();
        send_item(REQ_PREDICT, 32'hffff_ffff, PMAX, PMIN, 32'sd1, 0, 0, 0, 0);
        send_item(REQ_PREDICT, 32'h0, PMAX, PMIN, -32'sd1, PMAX, PMIN, 0, 32'hffff_ffff);
        send_item(REQ_UNUSED, 32'hffff_ffff, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX,
                  32'hffff_ffff);
        send_item(REQ_RECONCILE, 0, 0, 0, 0, PMAX, PMIN, 32'sd0, 32'd0);
        send_item(REQ_RECONCILE, 0, 0, 0, 0, PMIN, PMAX, -32'sd1, 32'd1);
        send_item(REQ_BIND, 32'h1234, PMIN, PMIN, PMIN, PMAX, PMIN, -32'sd5, 0);
        send_item(REQ_PREDICT, 32'h5555_aaaa, 32'sd1, -32'sd1, 32'sd10, 0, 0, 0, 0);
        send_item(REQ_PREDICT, 32'haaaa_5555, -32'sd1, 32'sd1, 32'sd10, 0, 0, 0, 0);
        send_item(REQ_RECONCILE, 0, 0, 0, 0, 32'sh100, 32'sh200, 32'sh300, 32'hffff_ffff);
        send_item(REQ_RECONCILE, 0, 0, 0, 0, 0, 0, 0, 32'hffff_ffff);  // empty ring
    endtask

    // overfill the ring, then drop part of it, then all of it
    task automatic test_ring_full();
        int i;
        send_item(REQ_BIND, 0, 0, 0, 0, 0, 0, 0, 0);
        for (i = 0; i < DEPTH + 3; i++) begin
            send_item(REQ_PREDICT, i, rand_val(), rand_val(), rand_val(), 0, 0, 0, 0);
            if (i % 8 == 0) idle_gap();
        end
        send_item(REQ_RECONCILE, 0, 0, 0, 0, rand_val(), rand_val(), rand_val(), 32'd0);
        send_item(REQ_RECONCILE, 0, 0, 0, 0, rand_val(), rand_val(), rand_val(), 32'd20);
        send_item(REQ_RECONCILE, 0, 0, 0, 0, rand_val(), rand_val(), rand_val(), 32'd500);
    endtask

    // sequence counter wrap: no bind resets it, so drive ~2^32 predicts is
    // impossible; instead wrap is reached only via the model-consistent path
    // of the counter, which the block cannot be preloaded to. Covered by
    // acks near the top of the range instead.

    // random sessions: bind, predicts, unused codes, reconciles with live, zero and random acks
    task automatic test_random(int total);
        t_req req;
        logic [31:0] ack;
        int k;
        k = 0;
        while (k < total) begin
            if ($urandom_range(0, 29) == 0) req = REQ_BIND;
            else if ($urandom_range(0, 39) == 0) req = REQ_UNUSED;
            else if ($urandom_range(0, 3) == 0) req = REQ_RECONCILE;
            else req = REQ_PREDICT;
            case ($urandom_range(0, 7))
                0: ack = 0;
                1: ack = $urandom();
                default: ack = next_seq - $urandom_range(1, count + 2);
            endcase
            send_item(req, $urandom(), rand_val(), rand_val(), rand_val(),
                      rand_val(), rand_val(), rand_val(), ack);
            k++;
            if (k == total / 2) drain();
            idle_gap();
        end
    endtask

    initial begin
        head = 0; count = 0; next_seq = 32'd1; newest_seq = 0;
        px = 0; py = 0; pz = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_ring_full();
        test_random(700);
        drain();
        repeat (200) @(posedge i_clk);
        $display("covered %0d items: %0d predicts (%0d with ring full), %0d reconciles",
                 n_items, n_predict, n_full, n_reconcile);
        if (errors == 0 && expected_q.size() == 0)
            $display("predict_replay_input_buffer_tb: done, clean");
        else
            $display("predict_replay_input_buffer_tb: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("predict_replay_input_buffer_tb: done, errors");
        $finish;
    end

endmodule
